[design/baro_ptc_pkg.sv]
// Shared types and constants for the barometer compensation pipeline.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none

package baro_ptc_pkg;

  // Stream and register port widths.
  localparam int InDataW  = 48;
  localparam int OutDataW = 56;
  localparam int AddrW    = 5;
  localparam int PDataW   = 32;
  localparam int CalW     = 16;

  // Item field widths.
  localparam int RawW    = 24;
  localparam int PressW  = 32;
  localparam int TempW   = 19;

  // Number of register stages in the compensation pipeline.
  localparam int NumStages = 9;

  // Sample gate and temperature thresholds.
  localparam logic [RawW-1:0]         GatePressureMin = 24'd6056977;
  localparam logic signed [TempW-1:0] TempRef         = 19'sd2000;
  // Distance from 20.00 degC down to -15.00 degC.
  localparam logic signed [TempW-1:0] ColdGap         = 19'sd3500;

  // Register map, one 32-bit word per calibration value.
  typedef enum logic [2:0] {
    RegPressureSens  = 3'd0,
    RegPressureOff   = 3'd1,
    RegSensTempCoef  = 3'd2,
    RegOffTempCoef   = 3'd3,
    RegRefTemp       = 3'd4,
    RegTempSlope     = 3'd5
  } cfg_reg_t;

  localparam logic [CalW-1:0] ResetC1 = 16'd40127;
  localparam logic [CalW-1:0] ResetC2 = 16'd36924;
  localparam logic [CalW-1:0] ResetC3 = 16'd23317;
  localparam logic [CalW-1:0] ResetC4 = 16'd23282;
  localparam logic [CalW-1:0] ResetC5 = 16'd33464;
  localparam logic [CalW-1:0] ResetC6 = 16'd28312;

endpackage

`default_nettype wire

[design/baro_pressure_temp_compensation.sv]
// Pipelined second-order pressure and temperature compensation for a barometer.
// Depends on baro_ptc_pkg for widths, thresholds, register codes and reset values.
`default_nettype none

// The block turns one pair of raw 24-bit conversions into a compensated
// pressure in pascal and a temperature in hundredths of a degree Celsius.
// The input stream carries one beat per sample; the output stream returns
// exactly one beat per input beat, in the same order. The six calibration
// words sit in registers behind the APB port at byte addresses 0 to 20 and
// must be written only while no sample is in flight.
//
// The datapath is a nine-stage pipeline. One beat is accepted every cycle
// while the receiver keeps tready high. The depth is set by the multiplier
// chain: the dT products, the two squares of the cold correction, and the
// 24 by 42 bit pressure product, which is split in two partial products and
// summed in a stage of its own.
//
// Every stage has a valid bit and loads whenever it is empty or the stage
// after it moves, so a stalled receiver holds the last stage and the upstream
// stages keep filling their bubbles; s_tready drops only once all nine stages
// are full. Nothing is dropped or repeated across a stall.
//
// Reset empties the pipeline and loads the calibration words with the
// factory defaults. A sample that fails the gate (raw pressure not above
// 6056977 or raw temperature zero) comes out with zero data and tuser low.

module baro_pressure_temp_compensation (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input stream.
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  // s_tdata: raw_pressure [23:0], raw_temperature [47:24].
  input  wire logic [baro_ptc_pkg::InDataW-1:0]  s_tdata,
  // Output stream.
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata: pressure_pa [31:0], temperature_centi [50:32], zero pad [55:51].
  output      logic [baro_ptc_pkg::OutDataW-1:0] m_tdata,
  // m_tuser: sample_valid [0].
  output      logic                              m_tuser,
  // Calibration register port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [baro_ptc_pkg::AddrW-1:0]    paddr,
  input  wire logic [baro_ptc_pkg::PDataW-1:0]   pwdata,
  output      logic [baro_ptc_pkg::PDataW-1:0]   prdata,
  output      logic                              pready
);

  import baro_ptc_pkg::*;

  // ---------------------------------------------------------------------
  // Calibration registers.
  // ---------------------------------------------------------------------
  logic [CalW-1:0] cal_c1, cal_c2, cal_c3, cal_c4, cal_c5, cal_c6;
  cfg_reg_t        cfg_sel;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_sel   = cfg_reg_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_c1 <= ResetC1;
      cal_c2 <= ResetC2;
      cal_c3 <= ResetC3;
      cal_c4 <= ResetC4;
      cal_c5 <= ResetC5;
      cal_c6 <= ResetC6;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        RegPressureSens: cal_c1 <= pwdata[CalW-1:0];
        RegPressureOff:  cal_c2 <= pwdata[CalW-1:0];
        RegSensTempCoef: cal_c3 <= pwdata[CalW-1:0];
        RegOffTempCoef:  cal_c4 <= pwdata[CalW-1:0];
        RegRefTemp:      cal_c5 <= pwdata[CalW-1:0];
        RegTempSlope:    cal_c6 <= pwdata[CalW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegPressureSens: prdata = {16'h0, cal_c1};
      RegPressureOff:  prdata = {16'h0, cal_c2};
      RegSensTempCoef: prdata = {16'h0, cal_c3};
      RegOffTempCoef:  prdata = {16'h0, cal_c4};
      RegRefTemp:      prdata = {16'h0, cal_c5};
      RegTempSlope:    prdata = {16'h0, cal_c6};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or drains.
  // ---------------------------------------------------------------------
  logic [NumStages:1] vld;
  logic [NumStages:1] rdy;

  always_comb begin
    rdy[NumStages] = !vld[NumStages] || m_tready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = rdy[1];
  assign m_tvalid = vld[NumStages];

  // ---------------------------------------------------------------------
  // Stage 1: gate and dT = D2 - C5*256.
  // ---------------------------------------------------------------------
  logic [RawW-1:0]    raw_p, raw_t;
  logic signed [24:0] dt_in;
  logic               gate_in;

  assign raw_p   = s_tdata[23:0];
  assign raw_t   = s_tdata[47:24];
  assign dt_in   = $signed({1'b0, raw_t}) - $signed({1'b0, cal_c5, 8'h00});
  assign gate_in = (raw_p > GatePressureMin) && (raw_t != '0);

  logic [RawW-1:0]    s1_d1;
  logic signed [24:0] s1_dt;
  logic               s1_gate;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_d1   <= raw_p;
      s1_dt   <= dt_in;
      s1_gate <= gate_in;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the four products of dT.
  // ---------------------------------------------------------------------
  logic signed [41:0] mul_c3, mul_c4, mul_c6;
  logic signed [49:0] mul_dd;

  assign mul_c3 = s1_dt * $signed({1'b0, cal_c3});
  assign mul_c4 = s1_dt * $signed({1'b0, cal_c4});
  assign mul_c6 = s1_dt * $signed({1'b0, cal_c6});
  assign mul_dd = s1_dt * s1_dt;

  logic [RawW-1:0]    s2_d1;
  logic               s2_gate;
  logic signed [41:0] s2_mc3, s2_mc4, s2_mc6;
  logic signed [49:0] s2_mdd;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_d1   <= s1_d1;
      s2_gate <= s1_gate;
      s2_mc3  <= mul_c3;
      s2_mc4  <= mul_c4;
      s2_mc6  <= mul_c6;
      s2_mdd  <= mul_dd;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: first-order TEMP, OFF and SENS, and the cold flags.
  // d is TEMP - 2000, e is TEMP + 1500.
  // ---------------------------------------------------------------------
  logic signed [41:0]      c6_shr;
  logic signed [TempW-1:0] d_in, e_in, temp_in;
  logic signed [41:0]      off_in, sens_in;

  assign c6_shr  = s2_mc6 >>> 23;
  assign d_in    = c6_shr[TempW-1:0];
  assign temp_in = d_in + TempRef;
  assign e_in    = d_in + ColdGap;
  assign off_in  = $signed({10'h0, cal_c2, 16'h0}) + (s2_mc4 >>> 7);
  assign sens_in = $signed({11'h0, cal_c1, 15'h0}) + (s2_mc3 >>> 8);

  logic [RawW-1:0]         s3_d1;
  logic                    s3_gate, s3_cold, s3_colder;
  logic signed [TempW-1:0] s3_d, s3_e, s3_temp;
  logic [TempW-1:0]        s3_tdd;
  logic signed [41:0]      s3_off, s3_sens;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_d1     <= s2_d1;
      s3_gate   <= s2_gate;
      s3_cold   <= d_in[TempW-1];
      s3_colder <= d_in < -ColdGap;
      s3_d      <= d_in;
      s3_e      <= e_in;
      s3_temp   <= temp_in;
      s3_tdd    <= s2_mdd[49:31];
      s3_off    <= off_in;
      s3_sens   <= sens_in;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: squares for the cold correction.
  // ---------------------------------------------------------------------
  logic signed [37:0] sq_d, sq_e;

  assign sq_d = s3_d * s3_d;
  assign sq_e = s3_e * s3_e;

  logic [RawW-1:0]         s4_d1;
  logic                    s4_gate, s4_cold, s4_colder;
  logic [35:0]             s4_dd, s4_ee;
  logic signed [TempW-1:0] s4_temp;
  logic [TempW-1:0]        s4_tdd;
  logic signed [41:0]      s4_off, s4_sens;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_d1     <= s3_d1;
      s4_gate   <= s3_gate;
      s4_cold   <= s3_cold;
      s4_colder <= s3_colder;
      s4_dd     <= sq_d[35:0];
      s4_ee     <= sq_e[35:0];
      s4_temp   <= s3_temp;
      s4_tdd    <= s3_tdd;
      s4_off    <= s3_off;
      s4_sens   <= s3_sens;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: scaled correction terms, and the dT squared term on TEMP.
  // ---------------------------------------------------------------------
  logic [38:0]             q5;
  logic [39:0]             e7, e11;
  logic [39:0]             off_q, sens_q, off_e, sens_e;
  logic signed [TempW-1:0] temp_fix;

  assign q5  = {1'b0, s4_dd, 2'b00} + {3'b000, s4_dd};
  assign e7  = {1'b0, s4_ee, 3'b000} - {4'h0, s4_ee};
  assign e11 = {1'b0, s4_ee, 3'b000} + {3'b000, s4_ee, 1'b0} + {4'h0, s4_ee};

  assign off_q    = s4_cold   ? {2'b00, q5[38:1]} : '0;
  assign sens_q   = s4_cold   ? {3'b000, q5[38:2]} : '0;
  assign off_e    = s4_colder ? e7 : '0;
  assign sens_e   = s4_colder ? {1'b0, e11[39:1]} : '0;
  assign temp_fix = s4_cold ? (s4_temp - $signed(s4_tdd)) : s4_temp;

  logic [RawW-1:0]         s5_d1;
  logic                    s5_gate;
  logic [39:0]             s5_off_q, s5_sens_q, s5_off_e, s5_sens_e;
  logic signed [TempW-1:0] s5_temp;
  logic signed [41:0]      s5_off, s5_sens;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_d1     <= s4_d1;
      s5_gate   <= s4_gate;
      s5_off_q  <= off_q;
      s5_sens_q <= sens_q;
      s5_off_e  <= off_e;
      s5_sens_e <= sens_e;
      s5_temp   <= temp_fix;
      s5_off    <= s4_off;
      s5_sens   <= s4_sens;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: final OFF and SENS.
  // ---------------------------------------------------------------------
  logic signed [41:0] off_fin, sens_fin;

  assign off_fin  = s5_off - $signed({2'b00, s5_off_q}) - $signed({2'b00, s5_off_e});
  assign sens_fin = s5_sens - $signed({2'b00, s5_sens_q}) - $signed({2'b00, s5_sens_e});

  logic [RawW-1:0]         s6_d1;
  logic                    s6_gate;
  logic signed [TempW-1:0] s6_temp;
  logic signed [41:0]      s6_off, s6_sens;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_d1   <= s5_d1;
      s6_gate <= s5_gate;
      s6_temp <= s5_temp;
      s6_off  <= off_fin;
      s6_sens <= sens_fin;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: D1 * SENS as two partial products (low 24 bits, signed top).
  // ---------------------------------------------------------------------
  logic [47:0]        pp_lo;
  logic signed [42:0] pp_hi;

  assign pp_lo = s6_d1 * s6_sens[23:0];
  assign pp_hi = $signed({1'b0, s6_d1}) * $signed(s6_sens[41:24]);

  logic                    s7_gate;
  logic signed [TempW-1:0] s7_temp;
  logic signed [41:0]      s7_off;
  logic [47:0]             s7_lo;
  logic signed [42:0]      s7_hi;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_gate <= s6_gate;
      s7_temp <= s6_temp;
      s7_off  <= s6_off;
      s7_lo   <= pp_lo;
      s7_hi   <= pp_hi;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: sum of the partial products. The full product stays below
  // 2^62 in magnitude, so the low 64 bits of the shifted top part suffice.
  // ---------------------------------------------------------------------
  logic [66:0] hi_shift;
  logic [63:0] prod_sum;

  assign hi_shift = {s7_hi, 24'h0};
  assign prod_sum = hi_shift[63:0] + {16'h0, s7_lo};

  logic                    s8_gate;
  logic signed [TempW-1:0] s8_temp;
  logic signed [41:0]      s8_off;
  logic signed [63:0]      s8_prod;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_gate <= s7_gate;
      s8_temp <= s7_temp;
      s8_off  <= s7_off;
      s8_prod <= $signed(prod_sum);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 9: P = (D1*SENS/2^21 - OFF)/2^15, then the output register.
  // ---------------------------------------------------------------------
  logic signed [63:0] prod_shr;
  logic signed [43:0] p_diff, p_shr;

  assign prod_shr = s8_prod >>> 21;
  assign p_diff   = $signed(prod_shr[43:0]) - s8_off;
  assign p_shr    = p_diff >>> 15;

  logic [PressW-1:0] out_press;
  logic [TempW-1:0]  out_temp;
  logic              out_gate;

  always_ff @(posedge clk) begin
    if (rdy[NumStages]) begin
      out_press <= s8_gate ? p_shr[PressW-1:0] : '0;
      out_temp  <= s8_gate ? s8_temp : '0;
      out_gate  <= s8_gate;
    end
  end

  assign m_tdata = {5'b00000, out_temp, out_press};
  assign m_tuser = out_gate;

endmodule

`default_nettype wire

[design/baro_ptc_checker.sv]
// Port-level checker for the barometer compensation block, with its bind.
// Depends on baro_ptc_pkg for port widths.
`default_nettype none

module baro_ptc_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [baro_ptc_pkg::OutDataW-1:0] m_tdata,
  input wire logic                              m_tuser
);

  import baro_ptc_pkg::*;

  // A result held back by the receiver keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // A rejected sample carries zero data.
  a_gate_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("gated sample carries nonzero data");

  // An open receiver keeps the whole pipeline moving.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while receiver is ready");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Padding above the temperature field is always zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OutDataW-1:51] == '0)
    else $error("nonzero pad bits in output beat");

endmodule

bind baro_pressure_temp_compensation baro_ptc_checker u_baro_ptc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[test/baro_pressure_temp_compensation_tb.sv]
// Self-checking testbench for the barometer pressure and temperature compensation block.
// Depends on baro_ptc_pkg and baro_pressure_temp_compensation; it drives both streams
// and the APB port and checks every output beat against its own integer predictor.
`default_nettype none

module baro_pressure_temp_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import baro_ptc_pkg::*;

  // Register map geometry: six 16-bit calibration words, one per 32-bit word.
  localparam int NumCalRegs = 6;
  localparam int AddrStride = 4;

  // Sample gate and temperature thresholds of the compensation, in 0.01 degC.
  localparam logic [RawW-1:0] SampleGate    = 24'd6056977;
  localparam logic [RawW-1:0] RawMax        = {RawW{1'b1}};
  localparam longint          TempRefCenti  = 2000;
  localparam longint          TempColdCenti = -1500;
  localparam longint          ColdGapCenti  = TempRefCenti - TempColdCenti;

  // Stream pacing and run limits.
  localparam int MaxIdle       = 12;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 20;
  localparam int PhaseCount    = 8;
  localparam int PhaseSamples  = 200;
  localparam int FloodSamples  = 40;

  typedef enum int {CalZero, CalMax, CalMixed} cal_pattern_t;

  typedef struct packed {
    logic [PressW-1:0] pressure_pa;
    logic [TempW-1:0]  temperature_centi;
    logic              sample_valid;
  } baro_reading_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // s_tdata: raw_pressure [23:0], raw_temperature [47:24].
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // m_tdata: pressure_pa [31:0], temperature_centi [50:32], zero pad [55:51].
  logic [OutDataW-1:0] m_tdata;
  // m_tuser: sample_valid [0].
  logic                m_tuser;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [AddrW-1:0]    paddr    = '0;
  logic [PDataW-1:0]   pwdata   = '0;
  logic [PDataW-1:0]   prdata;
  logic                pready;

  // Mirror of the calibration words, kept in step with every APB write.
  logic [CalW-1:0] cal_word [NumCalRegs] = '{ResetC1, ResetC2, ResetC3,
                                             ResetC4, ResetC5, ResetC6};

  // Readings predicted for accepted input beats, oldest first.
  baro_reading_t expected_readings [$];

  int mismatches    = 0;
  int beats_checked = 0;

  // Pacing controls shared with the driver and the sink. A quiet side never
  // idles; a nonzero hold request sets the length of the sink's next stall.
  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;
  int sink_hold  = 0;

  baro_pressure_temp_compensation i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Integer compensation of one raw pair under the mirrored calibration.
  // All intermediates are signed 64 bits and every power-of-two division is
  // an arithmetic shift, so negative values round toward minus infinity.
  function automatic baro_reading_t compensate(input logic [RawW-1:0] d1_raw,
                                               input logic [RawW-1:0] d2_raw);
    baro_reading_t r;
    longint d1, d2, dt, off, sens, temp, dev, sq, p;
    r = '0;
    if (d1_raw <= SampleGate || d2_raw == '0) begin
      return r;
    end
    d1   = longint'(d1_raw);
    d2   = longint'(d2_raw);
    dt   = d2 - longint'(cal_word[RegRefTemp]) * 256;
    off  = longint'(cal_word[RegPressureOff]) * 65536
         + ((longint'(cal_word[RegOffTempCoef]) * dt) >>> 7);
    sens = longint'(cal_word[RegPressureSens]) * 32768
         + ((longint'(cal_word[RegSensTempCoef]) * dt) >>> 8);
    temp = TempRefCenti + ((dt * longint'(cal_word[RegTempSlope])) >>> 23);
    // Second-order correction below 20 degC, with an extra term below
    // -15 degC; both use the first-order temperature.
    if (temp < TempRefCenti) begin
      dev  = temp - TempRefCenti;
      sq   = 5 * dev * dev;
      off  -= sq >>> 1;
      sens -= sq >>> 2;
      if (temp < TempColdCenti) begin
        dev  = temp - TempColdCenti;
        sq   = dev * dev;
        off  -= 7 * sq;
        sens -= (11 * sq) >>> 1;
      end
      temp -= (dt * dt) >>> 31;
    end
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    r.pressure_pa       = p[PressW-1:0];
    r.temperature_centi = temp[TempW-1:0];
    r.sample_valid      = 1'b1;
    return r;
  endfunction

  // Offers one raw pair after a random idle gap and waits for the beat to be
  // taken. tvalid stays high across back-to-back beats and is only lowered
  // when a gap follows, so it never gets two assignments in one time step.
  task automatic send_conversion(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {d2, d1};
    do @(posedge clk); while (!s_tready);
    expected_readings.push_back(compensate(d1, d2));
  endtask

  // Stops offering beats and waits until every predicted reading has come
  // out. Each sample gives exactly one result, so an empty queue means the
  // pipeline holds nothing and the calibration may be changed.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [PDataW-1:0] data);
    int idx;
    idx = int'(addr) / AddrStride;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // Writes beyond the last calibration word are ignored by the block.
    if (idx < NumCalRegs) begin
      cal_word[idx] = data[CalW-1:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Reads all six words back; prdata is taken at the edge that closes the
  // access cycle, with the value it held during that cycle.
  task automatic check_calibration_readback();
    logic [PDataW-1:0] got;
    logic [AddrW-1:0]  addr;
    cfg_reg_t          reg_id;
    for (int i = 0; i < NumCalRegs; i++) begin
      addr = AddrW'(AddrStride * i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      if (got !== PDataW'(cal_word[i])) begin
        reg_id = cfg_reg_t'(i);
        note_mismatch($sformatf("register %s: expected %0d, read %0d",
                                reg_id.name(), cal_word[i], got));
      end
    end
  endtask

  // Drains the block, rewrites every calibration word and reads them back.
  // Upper bits of pwdata are random: only the low 16 bits may be kept.
  task automatic load_calibration(input cal_pattern_t pattern);
    logic [CalW-1:0] word;
    drain_pipeline();
    for (int i = 0; i < NumCalRegs; i++) begin
      case (pattern)
        CalZero: word = '0;
        CalMax:  word = '1;
        default: begin
          case ($urandom_range(0, 3))
            0:       word = '0;
            1:       word = '1;
            default: word = CalW'($urandom);
          endcase
        end
      endcase
      apb_write(AddrW'(AddrStride * i), {CalW'($urandom), word});
    end
    check_calibration_readback();
  endtask

  function automatic logic [RawW-1:0] valid_pressure();
    return RawW'($urandom_range(SampleGate + 1, RawMax));
  endfunction

  // Both sides of the gate: pressure at and just above the threshold, a zero
  // temperature, and a zero pressure.
  task automatic test_gate_boundaries();
    send_conversion(SampleGate, RawMax);
    send_conversion(RawW'(SampleGate + 1), RawMax);
    send_conversion(valid_pressure(), '0);
    send_conversion('0, RawMax);
    send_conversion(RawW'(SampleGate + 1), 24'd1);
  endtask

  // Temperatures either side of 20 degC and of -15 degC under the reset
  // calibration: the first-order, the cold and the very cold paths.
  task automatic test_temperature_regions();
    longint ref_code, cold_dt;
    ref_code = longint'(cal_word[RegRefTemp]) * 256;
    cold_dt  = (ColdGapCenti <<< 23) / longint'(cal_word[RegTempSlope]);
    for (int k = -1; k <= 1; k++) begin
      send_conversion(valid_pressure(), RawW'(ref_code + k));
    end
    for (int k = -2; k <= 1; k++) begin
      send_conversion(valid_pressure(), RawW'(ref_code - cold_dt + k));
    end
  endtask

  // Corners of both raw fields inside the gate.
  task automatic test_field_extremes();
    send_conversion(RawMax, RawMax);
    send_conversion(RawMax, 24'd1);
    send_conversion(RawW'(SampleGate + 1), RawMax);
    send_conversion(RawMax, 24'h800000);
  endtask

  // All-zero and all-ones calibration, then writes to the two addresses past
  // the last register, which must leave every word as it was.
  task automatic test_register_extremes();
    load_calibration(CalZero);
    send_conversion(RawMax, RawMax);
    send_conversion(RawW'(SampleGate + 1), 24'd1);
    send_conversion(valid_pressure(), RawW'($urandom_range(1, RawMax)));
    load_calibration(CalMax);
    send_conversion(RawMax, RawMax);
    send_conversion(RawW'(SampleGate + 1), 24'd1);
    send_conversion(valid_pressure(), RawW'($urandom_range(1, RawMax)));
    drain_pipeline();
    apb_write(AddrW'(AddrStride * NumCalRegs), $urandom);
    apb_write(AddrW'(AddrStride * (NumCalRegs + 1)), $urandom);
    check_calibration_readback();
    send_conversion(valid_pressure(), RawW'($urandom_range(1, RawMax)));
    send_conversion(valid_pressure(), RawW'($urandom_range(1, RawMax)));
  endtask

  // The sink holds tready low for a long stretch while the source offers
  // beats back to back, so the pipeline fills and must stall its input.
  task automatic test_output_stall();
    drain_pipeline();
    sink_hold = HoldCycles;
    src_quiet = 1'b1;
    for (int n = 0; n < FloodSamples; n++) begin
      send_conversion(valid_pressure(), RawW'($urandom_range(1, RawMax)));
    end
    src_quiet = 1'b0;
  endtask

  // Random samples under several calibration sets. Most pairs pass the gate
  // so that the arithmetic is exercised; the rest fail on either field.
  task automatic test_random_phases();
    logic [RawW-1:0] d1, d2;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      load_calibration(CalMixed);
      for (int n = 0; n < PhaseSamples; n++) begin
        if (n % 50 == 0) begin
          src_quiet  = ($urandom_range(0, 3) == 0);
          sink_quiet = ($urandom_range(0, 3) == 0);
        end
        case ($urandom_range(0, 9))
          0: begin
            d1 = RawW'($urandom_range(0, SampleGate));
            d2 = RawW'($urandom);
          end
          1: begin
            d1 = RawW'($urandom);
            d2 = '0;
          end
          default: begin
            d1 = valid_pressure();
            d2 = RawW'($urandom_range(1, RawMax));
          end
        endcase
        send_conversion(d1, d2);
      end
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  // Output sink: draws a stall before every beat it takes. The first edge
  // after tready goes high always sees it high, so each pass of the loop
  // takes exactly one beat.
  initial begin : result_sink
    int stall;
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else if (sink_quiet) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MaxIdle);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // Compares each output beat with the oldest predicted reading; the pad
  // bits above the temperature must be zero.
  always @(posedge clk) begin
    baro_reading_t       want;
    logic [OutDataW-1:0] want_data;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_readings.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat: tdata %h tuser %b",
                                m_tdata, m_tuser));
      end else begin
        want      = expected_readings.pop_front();
        want_data = {{(OutDataW - PressW - TempW){1'b0}}, want.temperature_centi,
                     want.pressure_pa};
        if (m_tdata !== want_data || m_tuser !== want.sample_valid) begin
          note_mismatch($sformatf(
            "beat %0d: expected P %0d T %0d valid %b tdata %h, got P %0d T %0d valid %b tdata %h",
            beats_checked, $signed(want.pressure_pa), $signed(want.temperature_centi),
            want.sample_valid, want_data, $signed(m_tdata[PressW-1:0]),
            $signed(m_tdata[PressW+TempW-1:PressW]), m_tuser, m_tdata));
        end
      end
      beats_checked++;
    end
  end

  // Ends the run once no beat and no register access has completed for a
  // long time; the limit covers the deliberate output stall several times.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : test_sequence
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_calibration_readback();
    test_gate_boundaries();
    test_temperature_regions();
    test_field_extremes();
    test_register_extremes();
    test_output_stall();
    test_random_phases();
    drain_pipeline();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[baro_pressure_temp_compensation.f]
design/baro_ptc_pkg.sv
design/baro_pressure_temp_compensation.sv
design/baro_ptc_checker.sv
test/baro_pressure_temp_compensation_tb.sv
